FILE: design/image_rotate_nearest_defines.svh
// Assertion macros for the image_rotate_nearest checker.
// Needs clk and rst in the scope where a macro is used.
`ifndef IMAGE_ROTATE_NEAREST_DEFINES_SVH
`define IMAGE_ROTATE_NEAREST_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define IRN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset
`define IRN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/irn_pkg.sv
// Shared types and constants for the image rotation block.
// No dependencies.
package irn_pkg;

  localparam int COORD_W = 9;
  localparam int RGB_W   = 24;
  localparam int DIM_W   = 10;
  localparam int TRIG_W  = 16;
  localparam int CTR_W   = DIM_W + 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0]         WIDTH_RST  = 10'd512;
  localparam logic [DIM_W-1:0]         HEIGHT_RST = 10'd512;
  localparam logic signed [TRIG_W-1:0] COS_RST    = 16'sd16384;
  localparam logic signed [TRIG_W-1:0] SIN_RST    = 16'sd0;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } irn_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_COS    = 2'd2,
    REG_SIN    = 2'd3
  } irn_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAP,
    ST_DONE
  } irn_state_t;

  typedef struct packed {
    logic valid;
    logic in_frame;
  } irn_map_stat_t;

endpackage

FILE: design/irn_map.sv
// Inverse coordinate mapping pipeline: centre, rotate, recentre, bounds check,
// frame store address. Five stages. Depends on irn_pkg.
module irn_map
  import irn_pkg::*;
#(
  parameter int MAX_DIM = 512,
  parameter int FRAC_BITS = 14,
  localparam int AW = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [COORD_W-1:0]       x,
  input  logic [COORD_W-1:0]       y,
  input  logic [DIM_W-1:0]         width_cfg,
  input  logic [DIM_W-1:0]         height_cfg,
  input  logic signed [TRIG_W-1:0] cos_q,
  input  logic signed [TRIG_W-1:0] sin_q,
  output irn_map_stat_t            stat,
  output logic [AW-1:0]            addr
);

  localparam int PW   = TRIG_W + CTR_W;
  localparam int SW   = (FRAC_BITS + 2 > PW + 1) ? FRAC_BITS + 2 : PW + 1;
  localparam int CO_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam logic signed [SW-1:0] BIAS = SW'((64'd1 << FRAC_BITS) - 64'd1);

  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;
  logic [4:0]       vld;

  // stage 1: centred coordinates
  logic signed [CTR_W:0]   dx, dy, dx_adj, dy_adj;
  logic signed [CTR_W-1:0] cx, cy;
  // stage 2: products
  logic signed [PW-1:0]    p_cx, p_sy, p_cy, p_sx;
  // stage 3: rotated, truncated
  logic signed [SW-1:0]    sum_x, sum_y, adj_x, adj_y, rx, ry;
  // stage 4: source coordinates and bounds
  logic signed [SW:0]      tx, ty, tx_adj, ty_adj;
  logic signed [SW-1:0]    sxv, syv;
  logic                    in_x, in_y, inside4, inside5;
  logic [CO_W-1:0]         sx_c, sy_c;

  // clamp the frame to the store
  always_comb begin
    w = width_cfg;
    h = height_cfg;
    if (MAX_DIM < 1024 && 32'(width_cfg) > MAX_DIM) begin
      w = DIM_W'(MAX_DIM);
    end
    if (MAX_DIM < 1024 && 32'(height_cfg) > MAX_DIM) begin
      h = DIM_W'(MAX_DIM);
    end
  end

  always_comb begin
    dx     = (CTR_W+1)'({x, 1'b0}) - (CTR_W+1)'(w);
    dy     = (CTR_W+1)'({y, 1'b0}) - (CTR_W+1)'(h);
    // round the half toward zero
    dx_adj = dx + (CTR_W+1)'(dx[CTR_W]);
    dy_adj = dy + (CTR_W+1)'(dy[CTR_W]);

    sum_x  = SW'(p_cx) + SW'(p_sy);
    sum_y  = SW'(p_cy) - SW'(p_sx);
    adj_x  = sum_x + (sum_x[SW-1] ? BIAS : '0);
    adj_y  = sum_y + (sum_y[SW-1] ? BIAS : '0);

    tx     = {rx, 1'b0} + (SW+1)'(w);
    ty     = {ry, 1'b0} + (SW+1)'(h);
    tx_adj = tx + (SW+1)'(tx[SW]);
    ty_adj = ty + (SW+1)'(ty[SW]);
    sxv    = tx_adj[SW:1];
    syv    = ty_adj[SW:1];
    in_x   = !sxv[SW-1] && (sxv < SW'(w));
    in_y   = !syv[SW-1] && (syv < SW'(h));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], start};
    end
  end

  always_ff @(posedge clk) begin
    cx      <= dx_adj[CTR_W:1];
    cy      <= dy_adj[CTR_W:1];
    p_cx    <= PW'(cos_q) * PW'(cx);
    p_sy    <= PW'(sin_q) * PW'(cy);
    p_cy    <= PW'(cos_q) * PW'(cy);
    p_sx    <= PW'(sin_q) * PW'(cx);
    rx      <= adj_x >>> FRAC_BITS;
    ry      <= adj_y >>> FRAC_BITS;
    sx_c    <= sxv[CO_W-1:0];
    sy_c    <= syv[CO_W-1:0];
    inside4 <= in_x && in_y;
    addr    <= AW'(sy_c) * AW'(MAX_DIM) + AW'(sx_c);
    inside5 <= inside4;
  end

  assign stat.valid    = vld[4];
  assign stat.in_frame = inside5;

endmodule

FILE: design/irn_store.sv
// Frame store: one write port, one read port with registered read data.
// Depends on irn_pkg.
module irn_store
  import irn_pkg::*;
#(
  parameter int DEPTH = 262144,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [RGB_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [RGB_W-1:0] rdata
);

  logic [RGB_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/image_rotate_nearest.sv
// Top level: configuration registers, load/query sequencing, output register.
// Depends on irn_pkg, irn_map and irn_store.
//
//   channel  signals                    payload
//   in       in_valid / in_ready        op, pix_x, pix_y, pix_rgb
//   out      out_valid / out_ready      out_rgb, in_range
//   cfg      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Loads stream one per clock while no query is in flight and no result waits.
// A query passes through the five mapping stages, one frame store read and
// the transfer into the output register before the next item is accepted.
// in_ready drops while a query is in flight and while its result waits for space.
// Reset clears control state only; the frame store holds garbage until loaded.
module image_rotate_nearest
  import irn_pkg::*;
#(
  parameter int MAX_DIM = 512,
  parameter int TRIG_FRAC_BITS = 14,
  localparam int AW = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 op,
  input  logic [COORD_W-1:0]   pix_x,
  input  logic [COORD_W-1:0]   pix_y,
  input  logic [RGB_W-1:0]     pix_rgb,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [RGB_W-1:0]     out_rgb,
  output logic                 in_range,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TRIG_W-1:0]    cfg_data
);

  logic [DIM_W-1:0]         image_width;
  logic [DIM_W-1:0]         image_height;
  logic signed [TRIG_W-1:0] cos_q;
  logic signed [TRIG_W-1:0] sin_q;

  irn_state_t       state, state_next;
  irn_map_stat_t    map_stat;
  logic [AW-1:0]    map_addr;
  logic [AW-1:0]    load_addr;
  logic [RGB_W-1:0] rdata;
  logic             hit;
  logic             in_take, load_we, query_go, out_free, out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_take   = in_valid && in_ready;
  assign query_go  = in_take && (op == OP_QUERY);
  assign load_we   = in_take && (op == OP_LOAD)
                     && (32'(pix_x) < MAX_DIM) && (32'(pix_y) < MAX_DIM);
  assign load_addr = AW'(pix_y) * AW'(MAX_DIM) + AW'(pix_x);
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
      cos_q        <= COS_RST;
      sin_q        <= SIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (irn_reg_t'(cfg_index))
        REG_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        REG_COS:    cos_q        <= cfg_data;
        REG_SIN:    sin_q        <= cfg_data;
      endcase
    end
  end

  irn_map #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (TRIG_FRAC_BITS)
  ) u_map (
    .clk        (clk),
    .rst        (rst),
    .start      (query_go),
    .x          (pix_x),
    .y          (pix_y),
    .width_cfg  (image_width),
    .height_cfg (image_height),
    .cos_q      (cos_q),
    .sin_q      (sin_q),
    .stat       (map_stat),
    .addr       (map_addr)
  );

  irn_store #(
    .DEPTH (MAX_DIM * MAX_DIM)
  ) u_store (
    .clk   (clk),
    .we    (load_we),
    .waddr (load_addr),
    .wdata (pix_rgb),
    .re    (map_stat.valid && map_stat.in_frame),
    .raddr (map_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (query_go) begin
          state_next = ST_MAP;
        end
      end
      ST_MAP: begin
        if (map_stat.valid) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold the read data until the output register frees up
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_stat.valid) begin
      hit <= map_stat.in_frame;
    end
    if (out_load) begin
      out_rgb  <= hit ? rdata : '0;
      in_range <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: design/irn_checker.sv
// Port-level checks for image_rotate_nearest, bound to the top level.
// Depends on irn_pkg and image_rotate_nearest_defines.svh.
`include "image_rotate_nearest_defines.svh"

module irn_checker
  import irn_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             op,
  input logic             out_valid,
  input logic             out_ready,
  input logic [RGB_W-1:0] out_rgb,
  input logic             in_range
);

  `IRN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_rgb) && $stable(in_range), "out item changed while stalled")
  `IRN_ASSERT_NOW(a_miss_zero, out_valid && !in_range, out_rgb == '0, "out of range item carries nonzero pixel")
  `IRN_ASSERT_NEXT(a_query_lock, in_valid && in_ready && (op == OP_QUERY), !in_ready, "item accepted during a query")
  `IRN_ASSERT_NOW(a_reset_empty, $past(rst), !out_valid, "out_valid set right after reset")

endmodule

bind image_rotate_nearest irn_checker u_irn_checker (.*);
